// File: src/adcv_pkg.sv
`timescale 1ns / 1ps

package adcv_pkg;

  localparam int FS_W    = 14;
  localparam int LEVEL_W = 12;
  localparam int CFG_W   = 14;
  localparam int MV_W    = 14;
  localparam int REM_W   = 10;
  localparam int DIGIT_W = 4;
  localparam int SEG_W   = 7;

  localparam logic [1:0] CFG_FULL_SCALE = 2'd0;
  localparam logic [1:0] CFG_TRIGGER    = 2'd1;
  localparam logic [1:0] CFG_REARM      = 2'd2;

  localparam logic [FS_W-1:0]    FULL_SCALE_RST = 14'd5000;
  localparam logic [LEVEL_W-1:0] TRIGGER_RST    = 12'd1228;
  localparam logic [LEVEL_W-1:0] REARM_RST      = 12'd1147;

  localparam logic [MV_W-1:0] MV_MAX = 14'd9999;

  typedef struct packed {
    logic [FS_W-1:0]    full_scale;
    logic [LEVEL_W-1:0] trigger;
    logic [LEVEL_W-1:0] rearm;
  } cfg_t;

  typedef struct packed {
    logic pulse;
    logic armed;
  } trig_t;

  // Segments bit0=A .. bit6=G, active high
  function automatic logic [SEG_W-1:0] seg7(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] s;
    unique case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

// File: src/adcv_cfg.sv
`timescale 1ns / 1ps

module adcv_cfg
  import adcv_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_scale <= FULL_SCALE_RST;
      cfg_r.trigger    <= TRIGGER_RST;
      cfg_r.rearm      <= REARM_RST;
    end else if (cfg_wr_en) begin
      // drop writes to unused indexes
      unique case (cfg_index)
        CFG_FULL_SCALE: cfg_r.full_scale <= cfg_wdata[FS_W-1:0];
        CFG_TRIGGER:    cfg_r.trigger    <= cfg_wdata[LEVEL_W-1:0];
        CFG_REARM:      cfg_r.rearm      <= cfg_wdata[LEVEL_W-1:0];
        default:        ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// File: src/adcv_hyst.sv
`timescale 1ns / 1ps

module adcv_hyst
  import adcv_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
)
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [LEVEL_W-1:0]     trigger,
  input  logic [LEVEL_W-1:0]     rearm,
  output trig_t                  trig
);

  localparam int CMP_W = (SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W;

  logic             above_r;
  logic             above_nxt;
  logic [CMP_W-1:0] s_ext;
  logic [CMP_W-1:0] trig_ext;
  logic [CMP_W-1:0] rearm_ext;
  logic             fire;
  logic             release_lvl;

  assign s_ext     = CMP_W'(sample);
  assign trig_ext  = CMP_W'(trigger);
  assign rearm_ext = CMP_W'(rearm);

  assign fire        = !above_r && (s_ext > trig_ext);
  assign release_lvl = above_r && (s_ext < rearm_ext);

  always_comb begin
    priority if (fire) begin
      above_nxt = 1'b1;
    end else if (release_lvl) begin
      above_nxt = 1'b0;
    end else begin
      above_nxt = above_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      above_r <= 1'b0;
    end else if (en) begin
      above_r <= above_nxt;
    end
  end

  assign trig.pulse = fire;
  assign trig.armed = above_nxt;

endmodule

// File: src/adcv_thou_split.sv
`timescale 1ns / 1ps

module adcv_thou_split
  import adcv_pkg::*;
(
  input  logic [MV_W-1:0]    mv,
  output logic [DIGIT_W-1:0] digit,
  output logic [REM_W-1:0]   rem
);

  logic [MV_W-1:0] base;
  logic [MV_W-1:0] diff;

  // Compare against every multiple of 1000 at once; the highest match wins
  always_comb begin
    digit = '0;
    base  = '0;
    for (int k = 1; k <= 9; k++) begin
      if (mv >= MV_W'(k * 1000)) begin
        digit = DIGIT_W'(k);
        base  = MV_W'(k * 1000);
      end
    end
  end

  assign diff = mv - base;
  assign rem  = diff[REM_W-1:0];

endmodule

// File: src/adcv_sub_split.sv
`timescale 1ns / 1ps

module adcv_sub_split
  import adcv_pkg::*;
(
  input  logic [REM_W-1:0]   rem,
  output logic [DIGIT_W-1:0] tenths,
  output logic [DIGIT_W-1:0] hundredths,
  output logic [DIGIT_W-1:0] thousandths,
  output logic [SEG_W-1:0]   tenths_seg,
  output logic [SEG_W-1:0]   hundredths_seg,
  output logic [SEG_W-1:0]   thousandths_seg
);

  logic [REM_W-1:0] base_h;
  logic [REM_W-1:0] diff_h;
  logic [6:0]       rem_t;
  logic [6:0]       base_t;
  logic [6:0]       diff_t;

  always_comb begin
    tenths = '0;
    base_h = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem >= REM_W'(k * 100)) begin
        tenths = DIGIT_W'(k);
        base_h = REM_W'(k * 100);
      end
    end
  end

  assign diff_h = rem - base_h;
  assign rem_t  = diff_h[6:0];

  always_comb begin
    hundredths = '0;
    base_t     = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_t >= 7'(k * 10)) begin
        hundredths = DIGIT_W'(k);
        base_t     = 7'(k * 10);
      end
    end
  end

  assign diff_t      = rem_t - base_t;
  assign thousandths = diff_t[DIGIT_W-1:0];

  assign tenths_seg      = seg7(tenths);
  assign hundredths_seg  = seg7(hundredths);
  assign thousandths_seg = seg7(thousandths);

endmodule

// File: src/adc_voltage_readout_with_trigger.sv
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Payload
// in_       input      in_valid / in_stall   in_adc_sample
// out_      output     out_valid / out_stall digits, segment patterns, trigger, armed
// cfg_      input      cfg_wr_en             cfg_index, cfg_wdata
//
// One sample per cycle sustained while out_stall stays low; each sample taken into the input
// register moves on through the millivolt, thousands and output registers to the output.
// Reset (rst_n low, synchronous) empties the pipeline, clears the trigger flag and
// loads the register defaults.
// A stalled output holds its result; earlier stages keep filling until every stage
// is occupied, then in_stall rises.

module adc_voltage_readout_with_trigger
  import adcv_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
)
(
  input  logic                   clk,
  input  logic                   rst_n,

  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [SAMPLE_BITS-1:0] in_adc_sample,

  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [DIGIT_W-1:0]     out_ones_digit,
  output logic [DIGIT_W-1:0]     out_tenths_digit,
  output logic [DIGIT_W-1:0]     out_hundredths_digit,
  output logic [DIGIT_W-1:0]     out_thousandths_digit,
  output logic [SEG_W:0]         out_ones_segments,
  output logic [SEG_W-1:0]       out_tenths_segments,
  output logic [SEG_W-1:0]       out_hundredths_segments,
  output logic [SEG_W-1:0]       out_thousandths_segments,
  output logic                   out_trigger_pulse,
  output logic                   out_armed_state,

  input  logic                   cfg_wr_en,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata
);

  localparam int PROD_W = SAMPLE_BITS + FS_W;

  cfg_t cfg;
  trig_t trig;

  // stage 1: input register
  logic                   s1_valid_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  // stage 2: millivolts
  logic                   s2_valid_r;
  logic [MV_W-1:0]        s2_mv_r;
  trig_t                  s2_trig_r;
  // stage 3: thousands split
  logic                   s3_valid_r;
  logic [DIGIT_W-1:0]     s3_ones_r;
  logic [REM_W-1:0]       s3_rem_r;
  trig_t                  s3_trig_r;
  // stage 4: output register
  logic                   out_valid_r;
  logic [DIGIT_W-1:0]     out_ones_r;
  logic [DIGIT_W-1:0]     out_tenths_r;
  logic [DIGIT_W-1:0]     out_hundredths_r;
  logic [DIGIT_W-1:0]     out_thousandths_r;
  logic [SEG_W:0]         out_ones_seg_r;
  logic [SEG_W-1:0]       out_tenths_seg_r;
  logic [SEG_W-1:0]       out_hundredths_seg_r;
  logic [SEG_W-1:0]       out_thousandths_seg_r;
  trig_t                  out_trig_r;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;

  logic [PROD_W-1:0]  prod;
  logic [MV_W-1:0]    mv_raw;
  logic [MV_W-1:0]    mv_sat;
  logic [DIGIT_W-1:0] ones_d;
  logic [REM_W-1:0]   rem_d;
  logic [DIGIT_W-1:0] tenths_d;
  logic [DIGIT_W-1:0] hundredths_d;
  logic [DIGIT_W-1:0] thousandths_d;
  logic [SEG_W-1:0]   tenths_seg;
  logic [SEG_W-1:0]   hundredths_seg;
  logic [SEG_W-1:0]   thousandths_seg;

  assign s4_ready = !out_valid_r || !out_stall;
  assign s3_ready = !s3_valid_r || s4_ready;
  assign s2_ready = !s2_valid_r || s3_ready;
  assign s1_ready = !s1_valid_r || s2_ready;
  assign in_stall = !s1_ready;

  adcv_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // advance the flag only when the sample moves on, so it sees samples in order
  adcv_hyst #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_hyst (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (s1_valid_r && s2_ready),
    .sample  (s1_sample_r),
    .trigger (cfg.trigger),
    .rearm   (cfg.rearm),
    .trig    (trig)
  );

  assign prod   = PROD_W'(s1_sample_r) * PROD_W'(cfg.full_scale);
  assign mv_raw = prod[SAMPLE_BITS +: MV_W];
  assign mv_sat = (mv_raw > MV_MAX) ? MV_MAX : mv_raw;

  adcv_thou_split u_thou (
    .mv    (s2_mv_r),
    .digit (ones_d),
    .rem   (rem_d)
  );

  adcv_sub_split u_sub (
    .rem             (s3_rem_r),
    .tenths          (tenths_d),
    .hundredths      (hundredths_d),
    .thousandths     (thousandths_d),
    .tenths_seg      (tenths_seg),
    .hundredths_seg  (hundredths_seg),
    .thousandths_seg (thousandths_seg)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_ready) begin
        s2_valid_r <= s1_valid_r;
      end
      if (s3_ready) begin
        s3_valid_r <= s2_valid_r;
      end
      if (s4_ready) begin
        out_valid_r <= s3_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_sample_r <= in_adc_sample;
    end
    if (s2_ready && s1_valid_r) begin
      s2_mv_r   <= mv_sat;
      s2_trig_r <= trig;
    end
    if (s3_ready && s2_valid_r) begin
      s3_ones_r <= ones_d;
      s3_rem_r  <= rem_d;
      s3_trig_r <= s2_trig_r;
    end
    if (s4_ready && s3_valid_r) begin
      out_ones_r            <= s3_ones_r;
      out_tenths_r          <= tenths_d;
      out_hundredths_r      <= hundredths_d;
      out_thousandths_r     <= thousandths_d;
      // decimal point always lit on the volts digit
      out_ones_seg_r        <= {1'b1, seg7(s3_ones_r)};
      out_tenths_seg_r      <= tenths_seg;
      out_hundredths_seg_r  <= hundredths_seg;
      out_thousandths_seg_r <= thousandths_seg;
      out_trig_r            <= s3_trig_r;
    end
  end

  assign out_valid                = out_valid_r;
  assign out_ones_digit           = out_ones_r;
  assign out_tenths_digit         = out_tenths_r;
  assign out_hundredths_digit     = out_hundredths_r;
  assign out_thousandths_digit    = out_thousandths_r;
  assign out_ones_segments        = out_ones_seg_r;
  assign out_tenths_segments      = out_tenths_seg_r;
  assign out_hundredths_segments  = out_hundredths_seg_r;
  assign out_thousandths_segments = out_thousandths_seg_r;
  assign out_trigger_pulse        = out_trig_r.pulse;
  assign out_armed_state          = out_trig_r.armed;

endmodule

// File: src/adcv_checker.sv
`timescale 1ns / 1ps

module adcv_checker
  import adcv_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_stall,
  input logic [DIGIT_W-1:0] out_ones_digit,
  input logic [DIGIT_W-1:0] out_tenths_digit,
  input logic [DIGIT_W-1:0] out_hundredths_digit,
  input logic [DIGIT_W-1:0] out_thousandths_digit,
  input logic [SEG_W:0]     out_ones_segments,
  input logic               out_trigger_pulse,
  input logic               out_armed_state
);

  // a transaction that fires the trigger must leave the comparator latched
  a_pulse_latches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_trigger_pulse |-> out_armed_state)
    else $error("trigger pulse without armed state");

  a_digits_decimal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ones_digit <= 4'd9) && (out_tenths_digit <= 4'd9) &&
                  (out_hundredths_digit <= 4'd9) && (out_thousandths_digit <= 4'd9))
    else $error("digit out of decimal range");

  a_point_and_segments: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_ones_segments[SEG_W] &&
                  (out_ones_segments[SEG_W-1:0] == seg7(out_ones_digit)))
    else $error("volts segment pattern does not match digit");

  a_empty_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result presented straight after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_ones_digit) &&
                               $stable(out_thousandths_digit) && $stable(out_armed_state))
    else $error("stalled transaction changed");

endmodule

bind adc_voltage_readout_with_trigger adcv_checker u_adcv_checker (.*);
